/* sv/desa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package desa_pkg;

    localparam int FIELD_BITS          = 16;
    localparam int ALIGN_MASK_BITS     = 15;
    localparam int DEFAULT_OFFSET_BITS = 16;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [FIELD_BITS-1:0] REGION_SIZE_RESET = 16'hFFFF;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_ZERO_SIZE = 2'd1;
    localparam logic [1:0] STATUS_CROSS     = 2'd2;

    typedef enum logic [2:0] {
        OP_ALLOC_BOTTOM  = 3'd0,
        OP_ALLOC_TOP     = 3'd1,
        OP_FREE_BOTTOM   = 3'd2,
        OP_FREE_TOP      = 3'd3,
        OP_MARK_BOTTOM   = 3'd4,
        OP_MARK_TOP      = 3'd5,
        OP_CLEAR_BOTTOM  = 3'd6,
        OP_CLEAR_TOP     = 3'd7
    } op_t;

    typedef struct packed {
        logic [2:0]            req_type;
        logic [FIELD_BITS-1:0] req_size;
        logic [3:0]            align_log2;
        logic [FIELD_BITS-1:0] marker_value;
    } req_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] alloc_offset;
        logic [1:0]            status;
        logic [FIELD_BITS-1:0] bottom_mark;
        logic [FIELD_BITS-1:0] top_mark;
    } rsp_t;

    // decoded request as it waits in the queue
    typedef struct packed {
        op_t                        op;
        logic                       zero_size;
        logic [FIELD_BITS-1:0]      size;
        logic [ALIGN_MASK_BITS-1:0] amask;
        logic [FIELD_BITS-1:0]      marker;
    } cmd_t;

endpackage

`default_nettype wire

/* sv/desa_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module desa_front (
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire desa_pkg::req_t in_data,
    input  wire logic          queue_full,
    output logic               push,
    output desa_pkg::cmd_t     push_cmd
);
    import desa_pkg::*;

    logic [FIELD_BITS-1:0] align_one;

    always_comb
    begin
        align_one = FIELD_BITS'(1) << in_data.align_log2;

        push_cmd.op        = op_t'(in_data.req_type);
        push_cmd.zero_size = (in_data.req_size == '0);
        push_cmd.size      = in_data.req_size;
        push_cmd.amask     = ALIGN_MASK_BITS'(align_one - FIELD_BITS'(1));
        push_cmd.marker    = in_data.marker_value;
    end

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

endmodule

`default_nettype wire

/* sv/desa_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module desa_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire desa_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output logic                full,
    output logic                head_valid,
    output desa_pkg::cmd_t      head
);
    import desa_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    cmd_t                slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full       = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* sv/desa_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module desa_back #(
    parameter int OFFSET_BITS = desa_pkg::DEFAULT_OFFSET_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [desa_pkg::FIELD_BITS-1:0]   region_size,
    input  wire logic                              cmd_valid,
    input  wire desa_pkg::cmd_t                    cmd,
    output logic                                   cmd_pop,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output desa_pkg::rsp_t                         out_data
);
    import desa_pkg::*;

    // working width: room for alignment round-up plus size without wrap
    localparam int CW = ((OFFSET_BITS > FIELD_BITS) ? OFFSET_BITS : FIELD_BITS) + 2;
    localparam logic [CW-1:0] OFS_MAX = CW'({OFFSET_BITS{1'b1}});
    localparam logic [CW-1:0] RESET_W = CW'(REGION_SIZE_RESET);
    localparam logic [OFFSET_BITS-1:0] TOP_RESET =
        OFFSET_BITS'((RESET_W > OFS_MAX) ? OFS_MAX : RESET_W);

    logic [OFFSET_BITS-1:0] bottom_reg, bottom_next;
    logic [OFFSET_BITS-1:0] top_reg, top_next;
    logic                   out_valid_reg, out_valid_next;
    rsp_t                   out_reg;

    logic [CW-1:0] bot_w, top_w, size_w, amask_w, marker_w, rs_w, end_w;
    logic [CW-1:0] bstart_w, bstop_w, tdiff_w, tstart_w, res_w;
    logic [1:0]    res_status;

    assign cmd_pop = cmd_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        bot_w    = CW'(bottom_reg);
        top_w    = CW'(top_reg);
        size_w   = CW'(cmd.size);
        amask_w  = CW'(cmd.amask);
        marker_w = CW'(cmd.marker);
        rs_w     = CW'(region_size);
        end_w    = (rs_w > OFS_MAX) ? OFS_MAX : rs_w;

        bstart_w = (bot_w + amask_w) & ~amask_w;
        bstop_w  = bstart_w + size_w;
        tdiff_w  = top_w - size_w;
        tstart_w = tdiff_w & ~amask_w;

        bottom_next = bottom_reg;
        top_next    = top_reg;
        res_w       = '0;
        res_status  = STATUS_OK;

        unique case (cmd.op)
            OP_ALLOC_BOTTOM:
            begin
                if (cmd.zero_size)
                begin
                    res_status = STATUS_ZERO_SIZE;
                end
                else if (bstop_w < top_w)
                begin
                    bottom_next = OFFSET_BITS'(bstop_w);
                    res_w       = bstart_w;
                end
                else
                begin
                    res_status = STATUS_CROSS;
                end
            end
            OP_ALLOC_TOP:
            begin
                if (cmd.zero_size)
                begin
                    res_status = STATUS_ZERO_SIZE;
                end
                else if (size_w > top_w)
                begin
                    res_status = STATUS_CROSS;
                end
                else if (tstart_w > bot_w)
                begin
                    top_next = OFFSET_BITS'(tstart_w);
                    res_w    = tstart_w;
                end
                else
                begin
                    res_status = STATUS_CROSS;
                end
            end
            OP_FREE_BOTTOM:
            begin
                bottom_next = (size_w > bot_w) ? '0 : OFFSET_BITS'(bot_w - size_w);
            end
            OP_FREE_TOP:
            begin
                if (top_w >= end_w || size_w > end_w - top_w)
                begin
                    top_next = OFFSET_BITS'(end_w);
                end
                else
                begin
                    top_next = OFFSET_BITS'(top_w + size_w);
                end
            end
            OP_MARK_BOTTOM:
            begin
                if (marker_w < bot_w)
                begin
                    bottom_next = OFFSET_BITS'(marker_w);
                end
            end
            OP_MARK_TOP:
            begin
                if (marker_w > top_w && marker_w < end_w)
                begin
                    top_next = OFFSET_BITS'(marker_w);
                end
            end
            OP_CLEAR_BOTTOM:
            begin
                bottom_next = '0;
            end
            OP_CLEAR_TOP:
            begin
                top_next = OFFSET_BITS'(end_w);
            end
            default:
            begin
                res_status = STATUS_OK;
            end
        endcase

        if (cmd_pop)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bottom_reg    <= '0;
            top_reg       <= TOP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd_pop)
            begin
                bottom_reg <= bottom_next;
                top_reg    <= top_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            out_reg.alloc_offset <= FIELD_BITS'(res_w);
            out_reg.status       <= res_status;
            out_reg.bottom_mark  <= FIELD_BITS'(bottom_next);
            out_reg.top_mark     <= FIELD_BITS'(top_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

/* sv/double_ended_stack_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Double-ended stack allocator: keeps a bottom offset growing up from zero and a
// top offset growing down from region_size, and answers every request
// transaction (aligned allocate, free, marker rollback or clear at either end)
// with one result transaction carrying the allocated offset, a status code and
// both offsets as they stand after the request. Requests are decoded by a
// front stage into a two-entry queue; the back stage executes one queue entry
// per cycle while its result register is free or being taken, against the
// offset registers, and parks the result in an output register, so one
// transaction per cycle is sustained while out_stall is low, and up to two
// more request transactions are taken in while a result waits to be taken. A
// request passes through a queue slot and then the result register, and the
// combinational update of the offset registers (an align add, a size add and a
// compare) is what keeps the back stage at one request per cycle. region_size
// is written with cfg_we; the user writes it only while the block is idle, which
// the block does not enforce. Writing it does not move the top offset, it only
// takes effect on clears, saturating frees and top rollbacks. After reset the
// bottom offset is zero and the top offset is 65535, clipped to the offset width.

module double_ended_stack_allocator #(
    parameter int OFFSET_BITS = desa_pkg::DEFAULT_OFFSET_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire desa_pkg::req_t                  in_data,
    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output desa_pkg::rsp_t                       out_data,
    // region size register
    input  wire logic                            cfg_we,
    input  wire logic [desa_pkg::FIELD_BITS-1:0] cfg_data
);
    import desa_pkg::*;

    logic [FIELD_BITS-1:0] region_size_reg;

    logic queue_full;
    logic push;
    cmd_t push_cmd;
    logic head_valid;
    cmd_t head;
    logic pop;

    // configuration register; the user writes it only between transactions, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_size_reg <= REGION_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            region_size_reg <= cfg_data;
        end
    end

    // decode request type and alignment mask
    desa_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // decouples front from back so either side can stall alone
    desa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // owns the offsets and the result register
    desa_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .region_size (region_size_reg),
        .cmd_valid   (head_valid),
        .cmd         (head),
        .cmd_pop     (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire

/* sv/desa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module desa_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_stall,
    input wire desa_pkg::req_t                  in_data,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire desa_pkg::rsp_t                  out_data
);
    import desa_pkg::*;

    // a stalled request holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("request changed while stalled");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // a failed request never reports an offset
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STATUS_OK |-> out_data.alloc_offset == '0)
        else $error("failed request returned a nonzero offset");

    // a result rising from idle follows an accepted request
    a_rise_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a matching request");

    // a successful allocation never starts above the top offset
    a_top_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == STATUS_OK && out_data.alloc_offset != '0
        |-> out_data.alloc_offset <= out_data.top_mark)
        else $error("allocated offset above top offset");

endmodule

bind double_ended_stack_allocator desa_checker u_desa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import desa_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 6;
    // margin for the path through the queue slot and the result register
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int CYCLE_LIMIT   = 400000;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    req_t           in_data;
    logic           out_valid;
    logic           out_stall = 1'b0;
    rsp_t           out_data;
    logic           cfg_we;
    logic [15:0]    cfg_data;

    // shadow copy of the allocator state, advanced at each accepted request
    logic [15:0]    model_bottom;
    logic [15:0]    model_top;
    logic [15:0]    model_region;

    // answers still owed by the block, oldest first
    rsp_t           answer_q[$];

    int             fail_count = 0;
    int             cycle_count = 0;
    int             burst_left;
    bit             gaps_on;

    double_ended_stack_allocator #(
        .OFFSET_BITS(16)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // cycle counter doubles as the watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // receiver stall pattern: free running, light, heavy, then periodic,
    // stepped by bits 9:8 of the cycle counter
    always @(posedge clk)
    begin
        case (cycle_count[9:8])
            2'd0:    out_stall <= 1'b0;
            2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
            2'd2:    out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (cycle_count[2:0] < 3);
        endcase
    end

    // predicts the answer to one request and advances the shadow state
    function automatic rsp_t allocator_step(input req_t r);
        rsp_t        res;
        int unsigned amask;
        int unsigned start;
        int unsigned stop;
        res   = '0;
        amask = (32'd1 << r.align_log2) - 1;
        case (op_t'(r.req_type))
            OP_ALLOC_BOTTOM:
            begin
                if (r.req_size == 0)
                    res.status = STATUS_ZERO_SIZE;
                else
                begin
                    start = (model_bottom + amask) & ~amask;
                    stop  = start + r.req_size;
                    // the new bottom must stay strictly below the top
                    if (stop < model_top && stop <= 32'hFFFF)
                    begin
                        model_bottom     = stop[15:0];
                        res.alloc_offset = start[15:0];
                    end
                    else
                        res.status = STATUS_CROSS;
                end
            end
            OP_ALLOC_TOP:
            begin
                if (r.req_size == 0)
                    res.status = STATUS_ZERO_SIZE;
                else if (r.req_size > model_top)
                    res.status = STATUS_CROSS;
                else
                begin
                    // aligned downward, must stay strictly above the bottom
                    start = (model_top - r.req_size) & ~amask;
                    if (start > model_bottom)
                    begin
                        model_top        = start[15:0];
                        res.alloc_offset = start[15:0];
                    end
                    else
                        res.status = STATUS_CROSS;
                end
            end
            OP_FREE_BOTTOM:
                model_bottom = (r.req_size > model_bottom) ? 16'd0 : model_bottom - r.req_size;
            OP_FREE_TOP:
            begin
                // a top already above the region end also lands on it
                if (model_top >= model_region || r.req_size > model_region - model_top)
                    model_top = model_region;
                else
                    model_top = model_top + r.req_size;
            end
            OP_MARK_BOTTOM:
                if (r.marker_value < model_bottom)
                    model_bottom = r.marker_value;
            OP_MARK_TOP:
                if (r.marker_value > model_top && r.marker_value < model_region)
                    model_top = r.marker_value;
            OP_CLEAR_BOTTOM:
                model_bottom = 16'd0;
            default:
                model_top = model_region;
        endcase
        res.bottom_mark = model_bottom;
        res.top_mark    = model_top;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s expected %0d actual %0d", name, want_v, got_v);
            fail_count++;
        end
    endtask

    // result side: every accepted result transaction against the oldest answer
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (answer_q.size() == 0)
            begin
                $error("result transaction with no request outstanding: %p", out_data);
                fail_count++;
            end
            else
            begin
                want = answer_q.pop_front();
                check_field("alloc_offset", want.alloc_offset, out_data.alloc_offset);
                check_field("status", 16'(want.status), 16'(out_data.status));
                check_field("bottom_mark", want.bottom_mark, out_data.bottom_mark);
                check_field("top_mark", want.top_mark, out_data.top_mark);
            end
        end
    end

    function automatic req_t make_req(input op_t op, input int unsigned nbytes,
                                      input int unsigned alog, input int unsigned marker);
        req_t r;
        r.req_type     = op;
        r.req_size     = nbytes[15:0];
        r.align_log2   = alog[3:0];
        r.marker_value = marker[15:0];
        return r;
    endfunction

    // holds one request transaction until accepted, then maybe opens a gap
    task automatic send_req(input req_t r);
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        answer_q.push_back(allocator_step(r));
        if (gaps_on)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    // stop sending and let every outstanding answer come back
    task automatic drain();
        in_valid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // only called with the block idle
    task automatic write_region(input int unsigned value);
        cfg_we   <= 1'b1;
        cfg_data <= value[15:0];
        @(posedge clk);
        cfg_we       <= 1'b0;
        model_region  = value[15:0];
    endtask

    task automatic test_alloc_bottom();
        send_req(make_req(OP_ALLOC_BOTTOM, 0, 0, 0));
        send_req(make_req(OP_ALLOC_BOTTOM, 100, 0, 0));
        send_req(make_req(OP_ALLOC_BOTTOM, 1, 4, 0));
        // widest alignment and largest size overflow the region
        send_req(make_req(OP_ALLOC_BOTTOM, 65535, 15, 65535));
    endtask

    task automatic test_alloc_top();
        send_req(make_req(OP_ALLOC_TOP, 0, 0, 0));
        send_req(make_req(OP_ALLOC_TOP, 16, 3, 0));
        // size above the top offset
        send_req(make_req(OP_ALLOC_TOP, 65535, 0, 0));
        send_req(make_req(OP_ALLOC_TOP, 1000, 15, 0));
        // would land below the bottom
        send_req(make_req(OP_ALLOC_TOP, 32700, 0, 0));
    endtask

    task automatic test_markers();
        // rollback above the bottom is ignored, below it is taken
        send_req(make_req(OP_MARK_BOTTOM, 0, 0, 200));
        send_req(make_req(OP_MARK_BOTTOM, 0, 0, 50));
        // top rollback at the region end or under the top is ignored
        send_req(make_req(OP_MARK_TOP, 0, 0, 65535));
        send_req(make_req(OP_MARK_TOP, 0, 0, 100));
        send_req(make_req(OP_MARK_TOP, 0, 0, 40000));
    endtask

    task automatic test_frees();
        send_req(make_req(OP_FREE_BOTTOM, 10, 0, 0));
        send_req(make_req(OP_FREE_BOTTOM, 65535, 0, 0));
        send_req(make_req(OP_FREE_TOP, 100, 0, 0));
        send_req(make_req(OP_FREE_TOP, 65535, 0, 0));
    endtask

    task automatic test_clears();
        send_req(make_req(OP_ALLOC_BOTTOM, 1000, 2, 0));
        send_req(make_req(OP_CLEAR_BOTTOM, 0, 0, 0));
        send_req(make_req(OP_ALLOC_TOP, 500, 5, 0));
        send_req(make_req(OP_CLEAR_TOP, 0, 0, 0));
    endtask

    task automatic test_region_size();
        drain();
        // shrinking the region leaves the top above it until it moves
        write_region(1000);
        send_req(make_req(OP_FREE_TOP, 0, 0, 0));
        send_req(make_req(OP_MARK_TOP, 0, 0, 999));
        send_req(make_req(OP_ALLOC_BOTTOM, 1000, 0, 0));
        drain();
        // region of one: nothing fits at either end
        write_region(1);
        send_req(make_req(OP_CLEAR_TOP, 0, 0, 0));
        send_req(make_req(OP_ALLOC_BOTTOM, 1, 0, 0));
        send_req(make_req(OP_ALLOC_TOP, 1, 0, 0));
        drain();
    endtask

    // mostly well formed requests sized against the space left, some noise
    function automatic req_t gen_request();
        int unsigned space;
        int unsigned nbytes;
        int unsigned alog;
        int unsigned marker;
        int unsigned sel;
        op_t         op;
        if ($urandom_range(0, 11) == 0)
            return make_req(op_t'($urandom_range(0, 7)), $urandom_range(0, 65535),
                            $urandom_range(0, 15), $urandom_range(0, 65535));
        space  = (model_top > model_bottom) ? model_top - model_bottom : 0;
        alog   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
        marker = $urandom_range(0, 65535);
        nbytes = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(1, space / 4 + 1);
        if ($urandom_range(0, 19) == 0)
            nbytes = 0;
        sel = $urandom_range(0, 99);
        if (sel < 28)
            op = OP_ALLOC_BOTTOM;
        else if (sel < 56)
            op = OP_ALLOC_TOP;
        else if (sel < 66)
            op = OP_FREE_BOTTOM;
        else if (sel < 76)
            op = OP_FREE_TOP;
        else if (sel < 84)
            op = OP_MARK_BOTTOM;
        else if (sel < 92)
            op = OP_MARK_TOP;
        else if (sel < 96)
            op = OP_CLEAR_BOTTOM;
        else
            op = OP_CLEAR_TOP;
        // rollback targets mostly inside the range that is taken
        if (op == OP_MARK_BOTTOM && $urandom_range(0, 3) != 0)
            marker = $urandom_range(0, model_bottom);
        if (op == OP_MARK_TOP && $urandom_range(0, 3) != 0)
            marker = $urandom_range(model_top, model_region);
        return make_req(op, nbytes, alog, marker);
    endfunction

    task automatic test_random();
        int unsigned region_list[7];
        int unsigned per_phase;
        region_list = '{65535, 1, 2, 300, 0, 64, 65535};
        region_list[4] = $urandom_range(3, 65534);
        per_phase = RANDOM_ITEMS / 7;
        for (int p = 0; p < 7; p++)
        begin
            drain();
            write_region(region_list[p]);
            // every third phase runs back to back with no sender gaps
            gaps_on    = (p % 3 != 1);
            burst_left = $urandom_range(1, 24);
            for (int i = 0; i < per_phase; i++)
                send_req(gen_request());
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_data      <= '0;
        cfg_we       <= 1'b0;
        cfg_data     <= '0;
        model_bottom = 16'd0;
        model_top    = REGION_SIZE_RESET;
        model_region = REGION_SIZE_RESET;
        gaps_on      = 1'b1;
        burst_left   = 5;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_alloc_bottom();
        test_alloc_top();
        test_markers();
        test_frees();
        test_clears();
        test_region_size();
        test_random();
        drain();

        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

/* files.f */
sv/desa_pkg.sv
sv/desa_front.sv
sv/desa_queue.sv
sv/desa_back.sv
sv/double_ended_stack_allocator.sv
sv/desa_checker.sv
dv/testbench.sv
